// ----- hdl/rap_pkg.sv -----
// Shared types, constants and helpers for the rotate-and-project pipeline.
package rap_pkg;

    localparam int CoordW     = 24;
    localparam int CoefW      = 16;
    localparam int NearW      = 10;
    localparam int FarW       = 11;
    localparam int ColW       = 8;
    localparam int RowW       = 6;
    localparam int ScreenWidth  = 170;
    localparam int ScreenHeight = 40;
    localparam int PaddrW     = 5;

    // Rotation intermediates are not limited; 30 bits cover
    // three passes of a 16-bit Q2.14 coefficient pair on a 25-bit value.
    localparam int RotW       = 30;
    localparam int ProdW      = RotW + CoefW + 1;
    localparam int DivW       = 46;    // far*near << 24 fits in 46 bits
    localparam int QuotW      = 46;

    localparam logic signed [CoordW-1:0] Max24 = 24'sh7FFFFF;
    localparam logic signed [CoordW-1:0] Min24 = -24'sh800000;
    localparam logic signed [RotW-1:0]   PivotZ = 30'sd409600;

    typedef enum logic [2:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5,
        REG_NEAR  = 3'd6,
        REG_FAR   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CoefW-1:0] cos_x;
        logic signed [CoefW-1:0] sin_x;
        logic signed [CoefW-1:0] cos_y;
        logic signed [CoefW-1:0] sin_y;
        logic signed [CoefW-1:0] cos_z;
        logic signed [CoefW-1:0] sin_z;
        logic [NearW-1:0]        near_dist;
        logic [FarW-1:0]         far_dist;
    } cfg_t;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [CoordW-1:0] rot_x;
        logic signed [CoordW-1:0] rot_y;
        logic signed [CoordW-1:0] rot_z;
        logic [ColW-1:0]          screen_col;
        logic [RowW-1:0]          screen_row;
        logic signed [CoordW-1:0] depth;
        logic                     visible;
    } res_t;

    // Round to nearest, ties up, then arithmetic shift by 14.
    function automatic logic signed [RotW-1:0] rnd14(input logic signed [ProdW-1:0] v);
        logic signed [ProdW-1:0] a;
        a = v + ProdW'(8192);
        return RotW'(a >>> 14);
    endfunction

    function automatic logic signed [CoordW-1:0] sat_rot(input logic signed [RotW-1:0] v);
        if (v > RotW'(Max24))
            return Max24;
        else if (v < RotW'(Min24))
            return Min24;
        else
            return CoordW'(v);
    endfunction

endpackage

// ----- hdl/rap_stream_if.sv -----
// Valid/ready stream interface carrying one payload.
interface rap_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rap_regs.sv -----
// APB register file holding the rotation coefficients and clip distances.
module rap_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rap_pkg::PaddrW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output rap_pkg::cfg_t                  cfg
);
    rap_pkg::cfg_t    cfg_reg;
    rap_pkg::reg_idx_t idx;

    assign idx    = rap_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_x     <= 16'sd16384;
            cfg_reg.sin_x     <= '0;
            cfg_reg.cos_y     <= 16'sd16384;
            cfg_reg.sin_y     <= '0;
            cfg_reg.cos_z     <= 16'sd16384;
            cfg_reg.sin_z     <= '0;
            cfg_reg.near_dist <= 10'd40;
            cfg_reg.far_dist  <= 11'd220;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                rap_pkg::REG_COS_X: cfg_reg.cos_x     <= pwdata[15:0];
                rap_pkg::REG_SIN_X: cfg_reg.sin_x     <= pwdata[15:0];
                rap_pkg::REG_COS_Y: cfg_reg.cos_y     <= pwdata[15:0];
                rap_pkg::REG_SIN_Y: cfg_reg.sin_y     <= pwdata[15:0];
                rap_pkg::REG_COS_Z: cfg_reg.cos_z     <= pwdata[15:0];
                rap_pkg::REG_SIN_Z: cfg_reg.sin_z     <= pwdata[15:0];
                rap_pkg::REG_NEAR:  cfg_reg.near_dist <= pwdata[9:0];
                rap_pkg::REG_FAR:   cfg_reg.far_dist  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            rap_pkg::REG_COS_X: prdata = 32'(cfg_reg.cos_x);
            rap_pkg::REG_SIN_X: prdata = 32'(cfg_reg.sin_x);
            rap_pkg::REG_COS_Y: prdata = 32'(cfg_reg.cos_y);
            rap_pkg::REG_SIN_Y: prdata = 32'(cfg_reg.sin_y);
            rap_pkg::REG_COS_Z: prdata = 32'(cfg_reg.cos_z);
            rap_pkg::REG_SIN_Z: prdata = 32'(cfg_reg.sin_z);
            rap_pkg::REG_NEAR:  prdata = {22'd0, cfg_reg.near_dist};
            rap_pkg::REG_FAR:   prdata = {21'd0, cfg_reg.far_dist};
            default:            prdata = '0;
        endcase
    end
endmodule

// ----- hdl/rap_rotate.sv -----
// Six-stage rotation pipeline: products then rounded sums for Rz, Ry, Rx.
module rap_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  rap_pkg::vec_t                      in_pt,
    input  rap_pkg::cfg_t                      cfg,
    output logic                               out_valid,
    output rap_pkg::vec_t                      out_pt
);
    localparam int PW = rap_pkg::ProdW;
    localparam int RW = rap_pkg::RotW;

    logic [5:0] v_reg;
    // stage 0: products for Rz
    logic signed [PW-1:0] p0a_reg, p0b_reg, p0c_reg, p0d_reg;
    logic signed [RW-1:0] z0_reg;
    // stage 1: rounded Rz
    logic signed [RW-1:0] x1_reg, y1_reg, z1_reg;
    // stage 2: products for Ry
    logic signed [PW-1:0] p2a_reg, p2b_reg, p2c_reg, p2d_reg;
    logic signed [RW-1:0] y2_reg;
    // stage 3: rounded Ry
    logic signed [RW-1:0] x3_reg, y3_reg, z3_reg;
    // stage 4: products for Rx
    logic signed [PW-1:0] p4a_reg, p4b_reg, p4c_reg, p4d_reg;
    logic signed [RW-1:0] x4_reg;
    // stage 5: rounded Rx, saturated
    rap_pkg::vec_t o_reg;

    logic signed [RW-1:0] xi, yi, zi;
    logic signed [PW-1:0] cxz, sxz, cyz, syz, cxx, sxx;

    assign xi  = RW'(in_pt.x);
    assign yi  = RW'(in_pt.y);
    assign zi  = RW'(in_pt.z) - rap_pkg::PivotZ;
    assign cxz = PW'(cfg.cos_z);
    assign sxz = PW'(cfg.sin_z);
    assign cyz = PW'(cfg.cos_y);
    assign syz = PW'(cfg.sin_y);
    assign cxx = PW'(cfg.cos_x);
    assign sxx = PW'(cfg.sin_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0a_reg <= cxz * PW'(xi);
            p0b_reg <= sxz * PW'(yi);
            p0c_reg <= sxz * PW'(xi);
            p0d_reg <= cxz * PW'(yi);
            z0_reg  <= zi;

            x1_reg <= rap_pkg::rnd14(p0a_reg - p0b_reg);
            y1_reg <= rap_pkg::rnd14(p0c_reg + p0d_reg);
            z1_reg <= z0_reg;

            p2a_reg <= cyz * PW'(x1_reg);
            p2b_reg <= syz * PW'(z1_reg);
            p2c_reg <= syz * PW'(x1_reg);
            p2d_reg <= cyz * PW'(z1_reg);
            y2_reg  <= y1_reg;

            x3_reg <= rap_pkg::rnd14(p2a_reg + p2b_reg);
            z3_reg <= rap_pkg::rnd14(p2d_reg - p2c_reg);
            y3_reg <= y2_reg;

            p4a_reg <= cxx * PW'(y3_reg);
            p4b_reg <= sxx * PW'(z3_reg);
            p4c_reg <= sxx * PW'(y3_reg);
            p4d_reg <= cxx * PW'(z3_reg);
            x4_reg  <= x3_reg;

            o_reg.x <= rap_pkg::sat_rot(x4_reg);
            o_reg.y <= rap_pkg::sat_rot(rap_pkg::rnd14(p4a_reg - p4b_reg));
            o_reg.z <= rap_pkg::sat_rot(rap_pkg::rnd14(p4c_reg + p4d_reg)
                                        + rap_pkg::PivotZ);
        end
    end

    assign out_valid = v_reg[5];
    assign out_pt    = o_reg;
endmodule

// ----- hdl/rap_project.sv -----
// Projection pipeline: three pipelined radix-2 dividers sharing one z divisor.
module rap_project (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rap_pkg::vec_t        in_pt,
    input  rap_pkg::cfg_t        cfg,
    output logic                 out_valid,
    output rap_pkg::res_t        out_res
);
    localparam int N  = rap_pkg::DivW;     // dividend bits = steps
    localparam int DW = rap_pkg::CoordW;   // divisor magnitude bits
    localparam int RW = DW + 1;            // partial remainder bits
    localparam int CW = rap_pkg::ColW;
    localparam int HW = rap_pkg::RowW;
    localparam int S  = N + 3;             // stages: setup, N steps, two finish

    typedef struct packed {
        logic [N-1:0]  q;      // dividend bits shifted out / quotient in
        logic [RW-1:0] r;
    } div_t;

    typedef struct packed {
        rap_pkg::vec_t     pt;
        logic [DW-1:0]     dmag;
        logic              zpos;
        logic              zzero;
        logic              nd, nx, ny;   // quotient signs
        logic [rap_pkg::FarW:0] fn_sum;
    } side_t;

    logic [S-1:0]  v_reg;
    div_t  dd_reg [0:N];
    div_t  dx_reg [0:N];
    div_t  dy_reg [0:N];
    side_t sd_reg [0:N];

    // setup
    logic [DW-1:0] zmag, xmag, ymag;
    logic [N-1:0]  fn_num;
    logic signed [34:0] nx_prod, ny_prod;

    assign zmag    = in_pt.z[DW-1] ? DW'(-in_pt.z) : DW'(in_pt.z);
    assign fn_num  = (N'(cfg.far_dist) * N'(cfg.near_dist)) << 24;
    assign nx_prod = $signed({1'b0, cfg.near_dist}) * 35'(in_pt.x);
    assign ny_prod = $signed({1'b0, cfg.near_dist}) * 35'(in_pt.y);

    function automatic div_t div_step(input div_t a, input logic [DW-1:0] d);
        logic [RW-1:0] t;
        div_t o;
        t = {a.r[RW-2:0], a.q[N-1]};
        o.q = {a.q[N-2:0], 1'b0};
        if (t >= RW'(d))
        begin
            o.r = t - RW'(d);
            o.q[0] = 1'b1;
        end
        else
            o.r = t;
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[S-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0].q <= fn_num;
            dd_reg[0].r <= '0;
            dx_reg[0].q <= N'(nx_prod[34] ? -nx_prod : nx_prod);
            dx_reg[0].r <= '0;
            dy_reg[0].q <= N'(ny_prod[34] ? -ny_prod : ny_prod);
            dy_reg[0].r <= '0;
            sd_reg[0].pt     <= in_pt;
            sd_reg[0].dmag   <= zmag;
            sd_reg[0].zpos   <= !in_pt.z[DW-1] && (in_pt.z != '0);
            sd_reg[0].zzero  <= (in_pt.z == '0);
            sd_reg[0].nd     <= in_pt.z[DW-1];
            sd_reg[0].nx     <= nx_prod[34] ^ in_pt.z[DW-1];
            sd_reg[0].ny     <= ny_prod[34] ^ in_pt.z[DW-1];
            sd_reg[0].fn_sum <= (rap_pkg::FarW+1)'(cfg.far_dist)
                                + (rap_pkg::FarW+1)'(cfg.near_dist);
            for (int i = 0; i < N; i++)
            begin
                dd_reg[i+1] <= div_step(dd_reg[i], sd_reg[i].dmag);
                dx_reg[i+1] <= div_step(dx_reg[i], sd_reg[i].dmag);
                dy_reg[i+1] <= div_step(dy_reg[i], sd_reg[i].dmag);
                sd_reg[i+1] <= sd_reg[i];
            end
        end
    end

    // finish stage 1: signed quotients and depth
    logic signed [N:0]  qd, qx, qy;
    logic signed [N+1:0] dep_full;
    side_t sf;

    assign sf = sd_reg[N];
    assign qd = sf.nd ? -$signed({1'b0, dd_reg[N].q}) : $signed({1'b0, dd_reg[N].q});
    assign qx = sf.nx ? -$signed({1'b0, dx_reg[N].q}) : $signed({1'b0, dx_reg[N].q});
    assign qy = sf.ny ? -$signed({1'b0, dy_reg[N].q}) : $signed({1'b0, dy_reg[N].q});
    assign dep_full = $signed((N+2)'({sf.fn_sum, 12'd0})) - (N+2)'(qd);

    rap_pkg::vec_t f_pt_reg;
    logic signed [rap_pkg::CoordW-1:0] f_dep_reg;
    logic signed [13:0] f_c_reg, f_r_reg;
    logic f_cbig_reg, f_rbig_reg, f_zpos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_pt_reg   <= sf.pt;
            f_zpos_reg <= sf.zpos;
            if (sf.zzero)
                f_dep_reg <= rap_pkg::Max24;
            else if (dep_full > (N+2)'(rap_pkg::Max24))
                f_dep_reg <= rap_pkg::Max24;
            else if (dep_full < (N+2)'(rap_pkg::Min24))
                f_dep_reg <= rap_pkg::Min24;
            else
                f_dep_reg <= rap_pkg::CoordW'(dep_full);
            f_cbig_reg <= (qx > (N+1)'(4096)) || (qx < -(N+1)'(4096));
            f_rbig_reg <= (qy > (N+1)'(4096)) || (qy < -(N+1)'(4096));
            f_c_reg    <= 14'(qx) + 14'(rap_pkg::ScreenWidth / 2);
            f_r_reg    <= 14'(qy) + 14'(rap_pkg::ScreenHeight / 2);
        end
    end

    // finish stage 2: visibility
    rap_pkg::res_t o_reg;
    logic vis;

    assign vis = f_zpos_reg && !f_cbig_reg && !f_rbig_reg
                 && !f_c_reg[13] && (f_c_reg < 14'(rap_pkg::ScreenWidth))
                 && !f_r_reg[13] && (f_r_reg < 14'(rap_pkg::ScreenHeight));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg.rot_x      <= f_pt_reg.x;
            o_reg.rot_y      <= f_pt_reg.y;
            o_reg.rot_z      <= f_pt_reg.z;
            o_reg.depth      <= f_dep_reg;
            o_reg.visible    <= vis;
            o_reg.screen_col <= vis ? CW'(f_c_reg) : '0;
            o_reg.screen_row <= vis ? HW'(f_r_reg) : '0;
        end
    end

    assign out_valid = v_reg[S-1];
    assign out_res   = o_reg;
endmodule

// ----- hdl/rotate_and_project_point.sv -----
// Top level: point rotation and perspective projection pipeline.
//   channel   dir   payload                                           flow
//   pt_in     in    point_x, point_y, point_z                         valid/ready
//   res_out   out   rot_x/y/z, screen_col, screen_row, depth, visible valid/ready
//   apb       in    cos/sin about x, y, z, near_dist, far_dist        APB write/read
// One point per cycle while the output is not stalled.
// Rotation takes six stages; projection runs 46 radix-2 divide steps plus setup
// and two finishing stages. Whole pipe advances together; output stalls freeze
// it, so nothing is lost or repeated. Reset clears all valid bits.
module rotate_and_project_point (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rap_pkg::PaddrW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    rap_stream_if.sink                  pt_in,
    rap_stream_if.source                res_out
);
    rap_pkg::cfg_t cfg;
    logic          en, rot_valid, prj_valid;
    rap_pkg::vec_t rot_pt;
    rap_pkg::vec_t in_pt;
    rap_pkg::res_t res;

    rap_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    assign en          = res_out.ready || !prj_valid;
    assign pt_in.ready = en;
    assign in_pt.x     = pt_in.data.x;
    assign in_pt.y     = pt_in.data.y;
    assign in_pt.z     = pt_in.data.z;

    rap_rotate u_rot (
        .clk, .rst_n, .en,
        .in_valid  (pt_in.valid),
        .in_pt,
        .cfg,
        .out_valid (rot_valid),
        .out_pt    (rot_pt)
    );

    rap_project u_prj (
        .clk, .rst_n, .en,
        .in_valid  (rot_valid),
        .in_pt     (rot_pt),
        .cfg,
        .out_valid (prj_valid),
        .out_res   (res)
    );

    assign res_out.valid           = prj_valid;
    assign res_out.data.rot_x      = res.rot_x;
    assign res_out.data.rot_y      = res.rot_y;
    assign res_out.data.rot_z      = res.rot_z;
    assign res_out.data.screen_col = res.screen_col;
    assign res_out.data.screen_row = res.screen_row;
    assign res_out.data.depth      = res.depth;
    assign res_out.data.visible    = res.visible;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data))
        else $error("result changed under stall");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !prj_valid |-> pt_in.ready)
        else $error("input blocked while output empty");
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.data.visible |->
        res_out.data.screen_col == '0 && res_out.data.screen_row == '0)
        else $error("hidden point has screen position");
    a_zero_z_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.data.rot_z == '0 |->
        res_out.data.depth == rap_pkg::Max24 && !res_out.data.visible)
        else $error("zero depth handling wrong");
endmodule
